### design/igsc_pkg.sv
// ---------------------------------------------------------------------------
// igsc_pkg: shared types and constants of the image gradient unit
// Pixel and gradient widths, configuration register codes, window column
// and gradient pair types.
// ---------------------------------------------------------------------------
package igsc_pkg;

    localparam int PIX_W          = 8;
    localparam int GRAD_W         = 11;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 13;
    localparam int WIDTH_FIELD_W  = 11;
    localparam int HEIGHT_FIELD_W = 13;
    localparam int S_TDATA_W      = 8;
    localparam int M_TDATA_W      = 24;
    localparam int MIN_DIM        = 3;
    localparam int RESET_DIM      = 1024;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_USE_SOBEL    = 2'd0,
        CFG_IMAGE_WIDTH  = 2'd1,
        CFG_IMAGE_HEIGHT = 2'd2
    } cfg_idx_t;

    // which gradient feeds a top-row result
    typedef enum logic [1:0] {
        SEL_OWN,
        SEL_PREV1,
        SEL_PREV2
    } grad_sel_t;

    // one window column: top is two rows up, bot is the incoming pixel
    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } pix_col_t;

    // gx in the low bits, gy in the high bits
    typedef struct packed {
        logic signed [GRAD_W-1:0] gy;
        logic signed [GRAD_W-1:0] gx;
    } grad_t;

endpackage

### design/igsc_ram.sv
// ---------------------------------------------------------------------------
// igsc_ram: simple dual-port RAM
// One write port, one read port, registered read data. A read and a write
// to the same address in one cycle return the old contents.
// ---------------------------------------------------------------------------
module igsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### design/igsc_kernel.sv
// ---------------------------------------------------------------------------
// igsc_kernel: 3x3 window and gradient arithmetic
// Shifts a new pixel column into the window and registers gx/gy of the
// shifted window, Sobel or central differences, in units of 1/8.
// ---------------------------------------------------------------------------
module igsc_kernel import igsc_pkg::*; (
    input  logic     aclk,
    input  logic     shift_en,
    input  logic     use_sobel,
    input  pix_col_t col_in,
    output grad_t    grad
);

    pix_col_t mid_reg;
    pix_col_t right_reg;
    grad_t    grad_reg;
    grad_t    grad_next;

    logic signed [GRAD_W-1:0] dx_mid;
    logic signed [GRAD_W-1:0] dy_mid;
    logic signed [GRAD_W-1:0] corner_x;
    logic signed [GRAD_W-1:0] corner_y;

    function automatic logic signed [GRAD_W-1:0] px_ext(input logic [PIX_W-1:0] p);
        return $signed({{(GRAD_W-PIX_W){1'b0}}, p});
    endfunction

    // after the shift: left column = mid_reg, center = right_reg, right = col_in
    always_comb begin
        dx_mid   = px_ext(col_in.mid) - px_ext(mid_reg.mid);
        dy_mid   = px_ext(right_reg.bot) - px_ext(right_reg.top);
        corner_x = px_ext(col_in.top) + px_ext(col_in.bot)
                 - px_ext(mid_reg.top) - px_ext(mid_reg.bot);
        corner_y = px_ext(col_in.bot) + px_ext(mid_reg.bot)
                 - px_ext(col_in.top) - px_ext(mid_reg.top);
        if (use_sobel) begin
            grad_next.gx = (dx_mid <<< 1) + corner_x;
            grad_next.gy = (dy_mid <<< 1) + corner_y;
        end else begin
            grad_next.gx = dx_mid <<< 2;
            grad_next.gy = dy_mid <<< 2;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            mid_reg   <= right_reg;
            right_reg <= col_in;
            grad_reg  <= grad_next;
        end
    end

    assign grad = grad_reg;

endmodule

### design/image_gradient_sobel_central_unit.sv
// ---------------------------------------------------------------------------
// image_gradient_sobel_central_unit: streaming 3x3 image gradient
// Raster pixels in, per-pixel (gx, gy) out, border pixels take the gradient
// of the nearest interior pixel.
// ---------------------------------------------------------------------------
//  channel   ports            tdata / tuser (low bit up)          tlast
//  -------   --------------   ---------------------------------   ---------
//  input     s_t*             tdata: pixel[7:0]; tuser: flush     -
//  output    m_t*             tdata: grad_x[10:0], grad_y[21:11]  last pix
//  config    cfg_*            0 use_sobel, 1 width, 2 height      -
//
//  One request per clock sustained while m_tready allows. Accept to m_tvalid
//  passes the input register (pixel line read), the window/gradient register
//  (gradient line read) and the result register. The result for pixel k
//  leaves with request k+2W+2, so 2W+2 flush requests drain an image.
//  aresetn (sync, active low) resets counters, valid bits and configuration;
//  line buffers are not cleared. Back-pressure on m_tready stalls the stages
//  behind the result register; empty stages still take requests.
// ---------------------------------------------------------------------------
module image_gradient_sobel_central_unit import igsc_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [7:0] pixel
    input  logic                  s_tuser,   // [0] flush
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [10:0] grad_x, [21:11] grad_y, rest 0
    output logic                  m_tlast,
    // configuration writes
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WID_W = $clog2(MAX_WIDTH + 1);
    localparam int HGT_W = $clog2(MAX_HEIGHT + 1);
    localparam int ROW_W = $clog2(MAX_HEIGHT + 3);   // flush rows run to H+2
    localparam int RST_WIDTH  = (RESET_DIM > MAX_WIDTH)  ? MAX_WIDTH  : RESET_DIM;
    localparam int RST_HEIGHT = (RESET_DIM > MAX_HEIGHT) ? MAX_HEIGHT : RESET_DIM;

    // ---------------- configuration ----------------
    logic             use_sobel_reg, use_sobel_next;
    logic [WID_W-1:0] width_reg, width_next;
    logic [HGT_W-1:0] height_reg, height_next;
    logic             cfg_restart;
    logic [31:0]      raw_w, raw_h, eff_w, eff_h;

    // widths/heights are clamped once, at write time
    always_comb begin
        raw_w = 32'(cfg_data[WIDTH_FIELD_W-1:0]);
        raw_h = 32'(cfg_data[HEIGHT_FIELD_W-1:0]);
        if (raw_w < 32'(MIN_DIM)) begin
            eff_w = 32'(MIN_DIM);
        end else if (raw_w > 32'(MAX_WIDTH)) begin
            eff_w = 32'(MAX_WIDTH);
        end else begin
            eff_w = raw_w;
        end
        if (raw_h < 32'(MIN_DIM)) begin
            eff_h = 32'(MIN_DIM);
        end else if (raw_h > 32'(MAX_HEIGHT)) begin
            eff_h = 32'(MAX_HEIGHT);
        end else begin
            eff_h = raw_h;
        end
    end

    always_comb begin
        use_sobel_next = use_sobel_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        cfg_restart    = 1'b0;
        if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_index))
                CFG_USE_SOBEL: begin
                    use_sobel_next = cfg_data[0];
                    cfg_restart    = 1'b1;
                end
                CFG_IMAGE_WIDTH: begin
                    width_next  = WID_W'(eff_w);
                    cfg_restart = 1'b1;
                end
                CFG_IMAGE_HEIGHT: begin
                    height_next = HGT_W'(eff_h);
                    cfg_restart = 1'b1;
                end
                default: begin
                    cfg_restart = 1'b0;   // unused index: ignored
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            use_sobel_reg <= 1'b1;
            width_reg     <= WID_W'(RST_WIDTH);
            height_reg    <= HGT_W'(RST_HEIGHT);
        end else begin
            use_sobel_reg <= use_sobel_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
        end
    end

    logic [WID_W-1:0] wm1, wm2;
    logic [HGT_W-1:0] hm1, hm2;
    assign wm1 = width_reg  - WID_W'(1);
    assign wm2 = width_reg  - WID_W'(2);
    assign hm1 = height_reg - HGT_W'(1);
    assign hm2 = height_reg - HGT_W'(2);

    // ---------------- handshake / stage advance ----------------
    logic a_valid_reg, b_valid_reg, m_valid_reg;
    logic b_adv, a_adv, in_adv;
    logic accept, move_ab, move_bc;

    assign b_adv   = !m_valid_reg || m_tready;
    assign a_adv   = !b_valid_reg || b_adv;
    assign in_adv  = !a_valid_reg || a_adv;
    assign accept  = s_tvalid && in_adv;
    assign move_ab = a_valid_reg && a_adv;
    assign move_bc = b_valid_reg && b_adv;
    assign s_tready = in_adv;

    // ---------------- input / output position counters ----------------
    // (row, col) = input position; (orow, ocol) = pixel of the next result
    logic [COL_W-1:0] col_reg, col_next, ocol_reg, ocol_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [HGT_W-1:0] orow_reg, orow_next;
    logic             out_active_reg, out_active_next;

    logic             take, gwr, start, produce;
    logic             col_end, ocol_end, olast;
    logic [COL_W-1:0] rcol;
    logic             rpar;
    grad_sel_t        dsel;

    always_comb begin
        take     = row_reg < ROW_W'(height_reg);
        gwr      = take && (row_reg >= ROW_W'(2)) && (col_reg >= COL_W'(2));
        // first result (pixel 0) comes with the request at row 2, column 2
        start    = (row_reg == ROW_W'(2)) && (col_reg == COL_W'(2));
        produce  = out_active_reg || start;
        col_end  = WID_W'(col_reg) == wm1;
        ocol_end = WID_W'(ocol_reg) == wm1;
        olast    = ocol_end && (orow_reg == hm1);

        // clamp the result pixel into the interior
        if (ocol_reg == '0) begin
            rcol = COL_W'(1);
        end else if (ocol_end) begin
            rcol = COL_W'(wm2);
        end else begin
            rcol = ocol_reg;
        end
        if (orow_reg == '0) begin
            rpar = 1'b1;
        end else if (orow_reg == hm1) begin
            rpar = hm2[0];
        end else begin
            rpar = orow_reg[0];
        end

        // top-row results use row 1 gradients made by this request or the
        // one or two just before it, too recent for the line buffer
        if (ocol_reg == '0) begin
            dsel = SEL_OWN;
        end else if (ocol_end) begin
            dsel = SEL_PREV2;
        end else begin
            dsel = SEL_PREV1;
        end
    end

    always_comb begin
        col_next        = col_reg;
        row_next        = row_reg;
        ocol_next       = ocol_reg;
        orow_next       = orow_reg;
        out_active_next = out_active_reg;
        if (cfg_restart) begin
            col_next        = '0;
            row_next        = '0;
            ocol_next       = '0;
            orow_next       = '0;
            out_active_next = 1'b0;
        end else if (accept) begin
            if (produce && olast) begin
                // image done: next request starts a new one
                col_next        = '0;
                row_next        = '0;
                ocol_next       = '0;
                orow_next       = '0;
                out_active_next = 1'b0;
            end else begin
                if (col_end) begin
                    col_next = '0;
                    row_next = row_reg + ROW_W'(1);
                end else begin
                    col_next = col_reg + COL_W'(1);
                end
                if (produce) begin
                    out_active_next = 1'b1;
                    if (ocol_end) begin
                        ocol_next = '0;
                        orow_next = orow_reg + HGT_W'(1);
                    end else begin
                        ocol_next = ocol_reg + COL_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg        <= '0;
            row_reg        <= '0;
            ocol_reg       <= '0;
            orow_reg       <= '0;
            out_active_reg <= 1'b0;
        end else begin
            col_reg        <= col_next;
            row_reg        <= row_next;
            ocol_reg       <= ocol_next;
            orow_reg       <= orow_next;
            out_active_reg <= out_active_next;
        end
    end

    // ---------------- pixel line buffers, one per row parity ----------------
    logic [PIX_W-1:0] px_in;
    logic [PIX_W-1:0] pix_rd0, pix_rd1;

    assign px_in = s_tuser ? '0 : s_tdata[PIX_W-1:0];   // flush counts as zero

    igsc_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_pix_line0 (
        .aclk    (aclk),
        .wr_en   (accept && take && !row_reg[0]),
        .wr_addr (col_reg),
        .wr_data (px_in),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (pix_rd0)
    );

    igsc_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_pix_line1 (
        .aclk    (aclk),
        .wr_en   (accept && take && row_reg[0]),
        .wr_addr (col_reg),
        .wr_data (px_in),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (pix_rd1)
    );

    // ---------------- stage A: input register ----------------
    logic             a_take_reg, a_gwr_reg, a_par_reg, a_out_reg, a_last_reg;
    logic             a_row0_reg, a_rpar_reg;
    logic [COL_W-1:0] a_wcol_reg, a_rcol_reg;
    logic [PIX_W-1:0] a_px_reg;
    grad_sel_t        a_dsel_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (in_adv) begin
            a_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            a_take_reg <= take;
            a_gwr_reg  <= gwr;
            a_par_reg  <= row_reg[0];
            a_wcol_reg <= col_reg - COL_W'(1);
            a_px_reg   <= px_in;
            a_out_reg  <= produce;
            a_last_reg <= olast;
            a_row0_reg <= orow_reg == '0;
            a_rpar_reg <= rpar;
            a_rcol_reg <= rcol;
            a_dsel_reg <= dsel;
        end
    end

    // window column: the line of this row's parity still holds two rows up
    pix_col_t col_in;
    grad_t    kern_grad;

    assign col_in.top = a_par_reg ? pix_rd1 : pix_rd0;
    assign col_in.mid = a_par_reg ? pix_rd0 : pix_rd1;
    assign col_in.bot = a_px_reg;

    igsc_kernel u_kernel (
        .aclk      (aclk),
        .shift_en  (move_ab && a_take_reg),
        .use_sobel (use_sobel_reg),
        .col_in    (col_in),
        .grad      (kern_grad)
    );

    // ---------------- stage B: gradient register ----------------
    logic             b_gwr_reg, b_wpar_reg, b_out_reg, b_last_reg;
    logic             b_row0_reg, b_rpar_reg;
    logic [COL_W-1:0] b_wcol_reg;
    grad_sel_t        b_dsel_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (a_adv) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (move_ab) begin
            b_gwr_reg  <= a_gwr_reg;
            b_wpar_reg <= !a_par_reg;   // gradient of row r-1
            b_wcol_reg <= a_wcol_reg;
            b_out_reg  <= a_out_reg;
            b_last_reg <= a_last_reg;
            b_row0_reg <= a_row0_reg;
            b_rpar_reg <= a_rpar_reg;
            b_dsel_reg <= a_dsel_reg;
        end
    end

    // gradient line buffers, one per row parity
    grad_t grad_rd0, grad_rd1;

    igsc_ram #(.WIDTH(2 * GRAD_W), .DEPTH(MAX_WIDTH)) u_grad_line0 (
        .aclk    (aclk),
        .wr_en   (move_bc && b_gwr_reg && !b_wpar_reg),
        .wr_addr (b_wcol_reg),
        .wr_data (kern_grad),
        .rd_en   (move_ab),
        .rd_addr (a_rcol_reg),
        .rd_data (grad_rd0)
    );

    igsc_ram #(.WIDTH(2 * GRAD_W), .DEPTH(MAX_WIDTH)) u_grad_line1 (
        .aclk    (aclk),
        .wr_en   (move_bc && b_gwr_reg && b_wpar_reg),
        .wr_addr (b_wcol_reg),
        .wr_data (kern_grad),
        .rd_en   (move_ab),
        .rd_addr (a_rcol_reg),
        .rd_data (grad_rd1)
    );

    // gradients of the last two requests that left stage B
    grad_t hist1_reg, hist2_reg;

    always_ff @(posedge aclk) begin
        if (move_bc) begin
            hist1_reg <= kern_grad;
            hist2_reg <= hist1_reg;
        end
    end

    grad_t res_grad;

    always_comb begin
        if (b_row0_reg) begin
            case (b_dsel_reg)
                SEL_OWN:   res_grad = kern_grad;
                SEL_PREV1: res_grad = hist1_reg;
                SEL_PREV2: res_grad = hist2_reg;
                default:   res_grad = kern_grad;
            endcase
        end else begin
            res_grad = b_rpar_reg ? grad_rd1 : grad_rd0;
        end
    end

    // ---------------- result register ----------------
    grad_t out_grad_reg;
    logic  out_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (b_adv) begin
            m_valid_reg <= b_valid_reg && b_out_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (move_bc && b_out_reg) begin
            out_grad_reg <= res_grad;
            out_last_reg <= b_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - 2 * GRAD_W){1'b0}}, out_grad_reg};
    assign m_tlast  = out_last_reg;

endmodule

### test/image_gradient_sobel_central_unit_test.sv
// ---------------------------------------------------------------------------
// image_gradient_sobel_central_unit_test: self-checking bench for the
// streaming 3x3 gradient unit
// Streams raster images with drain requests through the unit and checks
// every (gx, gy, last) result against a cycle-free model of the line buffers
// and window. The bench covers both operators, clamped image sizes, flush and
// stray pixels, mid-image restarts and random stalls on both streams.
// ---------------------------------------------------------------------------
module image_gradient_sobel_central_unit_test import igsc_pkg::*; ;

    localparam int MAX_W         = 1024;
    localparam int MAX_H         = 4096;
    localparam int RESET_CYCLES  = 6;
    // leave margin for requests still in the pipeline before any register write
    localparam int PIPE_SETTLE   = 8;
    // requests in the whole run; random images fill up to this count
    localparam int TOTAL_ITEMS   = 1950;
    // watchdog bound for the whole run: about 2k requests with both streams
    // stalling plus drain pauses
    localparam int CYCLE_LIMIT   = 200000;
    localparam int MAX_REPORTS   = 10;
    // register index past the end of the map: must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct {
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
        logic                     last;
    } grad_result_t;

    typedef enum {
        PAT_RANDOM,
        PAT_RISE_X,
        PAT_FALL_X,
        PAT_RISE_Y,
        PAT_FALL_Y,
        PAT_CHECKER,
        PAT_FLAT_MAX
    } img_pattern_t;

    // ---------------------------------------------------------------------
    // DUT ports; every input starts at a known value
    // ---------------------------------------------------------------------
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;   // [7:0] pixel
    logic                  s_tuser   = 1'b0; // [0] flush
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;          // [10:0] grad_x, [21:11] grad_y
    logic                  m_tlast;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    image_gradient_sobel_central_unit #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // Gradient predictor state: line buffers, 3x3 window, raster position
    // and the three registers. Lines start at zero; no result of a complete
    // image ever reads an entry that was not written in that image.
    // ---------------------------------------------------------------------
    logic [PIX_W-1:0]         pix_line  [0:2*MAX_W-1];
    logic [2*GRAD_W-1:0]      grad_line [0:2*MAX_W-1];  // {gy, gx}
    logic [PIX_W-1:0]         win       [0:8];
    int unsigned              col_pos;
    int unsigned              row_pos;
    logic                     sobel_sel;
    logic [WIDTH_FIELD_W-1:0] width_reg;
    logic [HEIGHT_FIELD_W-1:0] height_reg;

    grad_result_t expected_grads [$];
    grad_result_t checked;

    int unsigned send_idle_pct = 20;
    int unsigned recv_idle_pct = 49;
    int unsigned items_sent    = 0;
    int unsigned results_seen  = 0;
    int unsigned images_seen   = 0;
    int unsigned writes_done   = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count   = 0;

    function automatic int unsigned geom_width();
        int unsigned w;
        w = 32'(width_reg);
        if (w < MIN_DIM) w = MIN_DIM;
        if (w > MAX_W) w = MAX_W;
        return w;
    endfunction

    function automatic int unsigned geom_height();
        int unsigned h;
        h = 32'(height_reg);
        if (h < MIN_DIM) h = MIN_DIM;
        if (h > MAX_H) h = MAX_H;
        return h;
    endfunction

    // requests in one image: every pixel plus the 2W+2 drain requests
    function automatic int unsigned full_image_items();
        return geom_width() * geom_height() + 2 * geom_width() + 2;
    endfunction

    task automatic restart_raster();
        col_pos = 0;
        row_pos = 0;
        foreach (win[i]) win[i] = '0;
    endtask

    // Advance the raster by one accepted request and queue the result it
    // releases, if any.
    task automatic predict_raster_step(input logic [PIX_W-1:0] pix, input logic flush);
        int unsigned  w, h, total, lag, n, k, r, c;
        logic [PIX_W-1:0] px, up1, up2;
        int           gx, gy;
        logic [2*GRAD_W-1:0] g;
        grad_result_t res;
        w     = geom_width();
        h     = geom_height();
        total = w * h;
        lag   = 2 * w + 2;
        n     = row_pos * w + col_pos;

        // pixels past the last row are dropped; flush inside the image is 0
        if (row_pos < h) begin
            px  = flush ? '0 : pix;
            up1 = pix_line[((row_pos + 1) & 1) * MAX_W + col_pos];
            up2 = pix_line[(row_pos & 1) * MAX_W + col_pos];
            pix_line[(row_pos & 1) * MAX_W + col_pos] = px;
            for (int i = 0; i < 3; i++) begin
                win[i*3]   = win[i*3+1];
                win[i*3+1] = win[i*3+2];
            end
            win[2] = up2;
            win[5] = up1;
            win[8] = px;
            if (row_pos >= 2 && col_pos >= 2) begin
                if (sobel_sel) begin
                    gx = 2 * (int'(win[5]) - int'(win[3]))
                       + (int'(win[2]) + int'(win[8]) - int'(win[0]) - int'(win[6]));
                    gy = 2 * (int'(win[7]) - int'(win[1]))
                       + (int'(win[8]) + int'(win[6]) - int'(win[2]) - int'(win[0]));
                end else begin
                    gx = 4 * (int'(win[5]) - int'(win[3]));
                    gy = 4 * (int'(win[7]) - int'(win[1]));
                end
                grad_line[((row_pos - 1) & 1) * MAX_W + col_pos - 1] =
                    {gy[GRAD_W-1:0], gx[GRAD_W-1:0]};
            end
        end

        // result for pixel n-lag, position clamped onto the interior
        if (n >= lag && n - lag < total) begin
            k = n - lag;
            r = k / w;
            c = k % w;
            if (r < 1) r = 1;
            if (r > h - 2) r = h - 2;
            if (c < 1) c = 1;
            if (c > w - 2) c = w - 2;
            g        = grad_line[(r & 1) * MAX_W + c];
            res.gx   = g[GRAD_W-1:0];
            res.gy   = g[2*GRAD_W-1:GRAD_W];
            res.last = (k == total - 1);
            expected_grads.push_back(res);
            if (res.last) begin
                restart_raster();
                return;
            end
        end

        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
        end
    endtask

    // ---------------------------------------------------------------------
    // Result side: random back-pressure and the checker
    // ---------------------------------------------------------------------
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (m_tlast === 1'b1) images_seen++;
            if (expected_grads.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("ERROR: unexpected result gx=%0d gy=%0d last=%0b",
                             $signed(m_tdata[GRAD_W-1:0]),
                             $signed(m_tdata[2*GRAD_W-1:GRAD_W]), m_tlast);
            end else begin
                checked = expected_grads.pop_front();
                if (m_tdata[GRAD_W-1:0] !== checked.gx
                        || m_tdata[2*GRAD_W-1:GRAD_W] !== checked.gy
                        || m_tlast !== checked.last
                        || m_tdata[M_TDATA_W-1:2*GRAD_W] !== '0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("ERROR: result %0d: expected gx=%0d gy=%0d last=%0b, got gx=%0d gy=%0d last=%0b pad=%0h",
                                 results_seen, checked.gx, checked.gy, checked.last,
                                 $signed(m_tdata[GRAD_W-1:0]),
                                 $signed(m_tdata[2*GRAD_W-1:GRAD_W]), m_tlast,
                                 m_tdata[M_TDATA_W-1:2*GRAD_W]);
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_grads.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------

    // One request on the input stream, with random idle cycles ahead of it.
    // s_tvalid stays high when the next call follows at once.
    task automatic send_item(input logic [PIX_W-1:0] px, input logic fl);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= S_TDATA_W'($urandom_range(255));
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        s_tuser  <= fl;
        do @(posedge aclk); while (s_tready !== 1'b1);
        items_sent++;
        predict_raster_step(px, fl);
    endtask

    // Stop sending and let every queued result come out, then let requests
    // that release no result clear the pipeline.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_grads.size() != 0) @(posedge aclk);
        repeat (PIPE_SETTLE) @(posedge aclk);
    endtask

    // Drives one register; the caller drops cfg_wr_en after the last write.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        writes_done++;
        case (idx)
            CFG_USE_SOBEL: begin
                sobel_sel = data[0];
                restart_raster();
            end
            CFG_IMAGE_WIDTH: begin
                width_reg = data[WIDTH_FIELD_W-1:0];
                restart_raster();
            end
            CFG_IMAGE_HEIGHT: begin
                height_reg = data[HEIGHT_FIELD_W-1:0];
                restart_raster();
            end
            default: ;
        endcase
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] sobel_data,
                             input logic [CFG_DATA_W-1:0] width_data,
                             input logic [CFG_DATA_W-1:0] height_data);
        wait_idle();
        write_register(CFG_USE_SOBEL, sobel_data);
        write_register(CFG_IMAGE_WIDTH, width_data);
        write_register(CFG_IMAGE_HEIGHT, height_data);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [PIX_W-1:0] pattern_pixel(input img_pattern_t pat,
                                                       input int unsigned r,
                                                       input int unsigned c);
        case (pat)
            PAT_RISE_X:   return (c > 1) ? 8'hFF : 8'h00;
            PAT_FALL_X:   return (c > 1) ? 8'h00 : 8'hFF;
            PAT_RISE_Y:   return (r > 1) ? 8'hFF : 8'h00;
            PAT_FALL_Y:   return (r > 1) ? 8'h00 : 8'hFF;
            PAT_CHECKER:  return ((r + c) & 1) ? 8'hFF : 8'h00;
            PAT_FLAT_MAX: return 8'hFF;
            default:      return PIX_W'($urandom_range(255));
        endcase
    endfunction

    // Requests first .. first+count-1 of the current image. Noisy streams
    // drop some flush requests into the pixels and some stray pixels into
    // the drain.
    task automatic stream_items(input img_pattern_t pat, input bit noisy,
                                input int unsigned first, input int unsigned count);
        int unsigned w, h;
        logic [PIX_W-1:0] px;
        logic fl;
        w = geom_width();
        h = geom_height();
        for (int unsigned i = first; i < first + count; i++) begin
            if (i < w * h) begin
                fl = noisy && ($urandom_range(11) == 0);
                px = fl ? 8'($urandom_range(255)) : pattern_pixel(pat, i / w, i % w);
            end else begin
                fl = noisy ? ($urandom_range(3) != 0) : 1'b1;
                px = PIX_W'($urandom_range(255));
            end
            send_item(px, fl);
        end
    endtask

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // Reset geometry is 1024 x 1024 with Sobel: a short stream must stay
    // silent. Then only the width drops to 3, so Sobel and the 1024-row
    // height still come from reset while results flow. The image is
    // abandoned by the next register write, which checks the restart.
    task automatic test_reset_geometry();
        stream_items(PAT_RANDOM, 1'b0, 0, 40);
        wait_idle();
        write_register(CFG_IMAGE_WIDTH, 3);
        cfg_wr_en <= 1'b0;
        stream_items(PAT_RANDOM, 1'b0, 0, 60);
    endtask

    // Full-scale edges in both directions, for both operators.
    task automatic test_gradient_extremes();
        configure(1, 3, 3);
        stream_items(PAT_RISE_X, 1'b0, 0, full_image_items());
        stream_items(PAT_FALL_Y, 1'b0, 0, full_image_items());
        stream_items(PAT_CHECKER, 1'b0, 0, full_image_items());
        stream_items(PAT_FLAT_MAX, 1'b0, 0, full_image_items());
        // only bit 0 of the operator register counts
        configure(13'h1FFE, 3, 3);
        stream_items(PAT_FALL_X, 1'b0, 0, full_image_items());
        stream_items(PAT_RISE_Y, 1'b0, 0, full_image_items());
    endtask

    // Flush requests inside the image read as black; pixels in the drain are
    // ignored.
    task automatic test_irregular_stream();
        configure(1, 5, 4);
        stream_items(PAT_RANDOM, 1'b1, 0, full_image_items());
        configure(0, 4, 5);
        stream_items(PAT_RANDOM, 1'b1, 0, full_image_items());
    endtask

    // A write to the unused index mid-image must not restart the image.
    // The sender also holds off here until every queued result is out.
    task automatic test_unused_register();
        configure(1, 6, 5);
        stream_items(PAT_RANDOM, 1'b0, 0, 20);
        wait_idle();
        write_register(CFG_UNUSED, CFG_DATA_W'($urandom_range(8191)));
        cfg_wr_en <= 1'b0;
        stream_items(PAT_RANDOM, 1'b0, 20, full_image_items() - 20);
    endtask

    // Width and height outside 3..MAX clamp to the nearest limit; the width
    // register keeps only its low 11 bits. Upper limits run only a short
    // stretch of their image, since a full one takes thousands of requests.
    task automatic test_size_clamps();
        configure(1, 0, 0);
        stream_items(PAT_RANDOM, 1'b0, 0, full_image_items());
        configure(0, 13'h1804, 2);
        stream_items(PAT_RANDOM, 1'b0, 0, full_image_items());
        configure(1, 13'h1002, 1);
        stream_items(PAT_RANDOM, 1'b1, 0, full_image_items());
        configure(1, 2047, 3);
        stream_items(PAT_RANDOM, 1'b0, 0, 40);
        configure(0, 3, 8191);
        stream_items(PAT_RANDOM, 1'b0, 0, 60);
    endtask

    // Mostly whole small images back to back, some noisy, some cut short and
    // restarted by a register write, some paused until drained.
    task automatic test_random_images();
        int unsigned full, cut, roll;
        bit          reconfig;
        reconfig = 1'b1;
        while (items_sent < TOTAL_ITEMS) begin
            if (items_sent < TOTAL_ITEMS / 3) begin
                send_idle_pct = 20;
                recv_idle_pct = 49;
            end else if (items_sent < 2 * TOTAL_ITEMS / 3) begin
                send_idle_pct = 49;
                recv_idle_pct = 20;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            if (reconfig || $urandom_range(1) == 0)
                configure(CFG_DATA_W'($urandom_range(8191)),
                          ($urandom_range(15) == 0) ? CFG_DATA_W'($urandom_range(64, 13))
                                                    : CFG_DATA_W'($urandom_range(12, 0)),
                          CFG_DATA_W'($urandom_range(8, 0)));
            reconfig = 1'b0;

            full = full_image_items();
            roll = $urandom_range(9);
            if (roll == 0) begin
                // abandon the image part way; the next write restarts it
                cut = $urandom_range(full - 1, 1);
                stream_items(PAT_RANDOM, 1'b1, 0, cut);
                reconfig = 1'b1;
            end else if (roll == 1) begin
                cut = $urandom_range(full - 1, 1);
                stream_items(PAT_RANDOM, 1'b0, 0, cut);
                wait_idle();
                stream_items(PAT_RANDOM, 1'b0, cut, full - cut);
            end else begin
                stream_items(PAT_RANDOM, $urandom_range(3) == 0, 0, full);
            end
        end
    endtask

    // ---------------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------------
    initial begin
        sobel_sel  = 1'b1;
        width_reg  = WIDTH_FIELD_W'(RESET_DIM);
        height_reg = HEIGHT_FIELD_W'(RESET_DIM);
        foreach (pix_line[i]) pix_line[i] = '0;
        foreach (grad_line[i]) grad_line[i] = '0;
        restart_raster();

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_geometry();
        test_gradient_extremes();
        test_irregular_stream();
        test_unused_register();
        test_size_clamps();
        test_random_images();

        // drain, then give stray results time to show up
        wait_idle();
        repeat (4 * PIPE_SETTLE) @(posedge aclk);
        mismatch_count += expected_grads.size();

        $display("Run: %0d requests, %0d results, %0d complete images, %0d register writes",
                 items_sent, results_seen, images_seen, writes_done);
        $display("Both operators, clamped sizes, flush/stray pixels, restarts, three stall mixes");
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

### files.f
design/igsc_pkg.sv
design/igsc_ram.sv
design/igsc_kernel.sv
design/image_gradient_sobel_central_unit.sv
test/image_gradient_sobel_central_unit_test.sv
